FILE: hdl/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types, constants and helpers for the pressure compensation pipeline.
// ----------------------------------------------------------------------------
package psc_pkg;

    localparam int DIV_BITS = 32;

    localparam logic [31:0] B6_OFFSET  = 32'd4000;
    localparam logic [31:0] B4_BIAS    = 32'd32768;
    localparam logic [31:0] B7_SCALE   = 32'd50000;
    localparam logic [31:0] P_SQ_COEF  = 32'd3038;
    localparam logic [31:0] P_LIN_COEF = 32'hFFFF_E343;  // -7357
    localparam logic [31:0] P_OFFSET   = 32'd3791;

    typedef enum logic [2:0] {
        CFG_AC1_AC2 = 3'd0,
        CFG_AC3_AC4 = 3'd1,
        CFG_AC5_AC6 = 3'd2,
        CFG_B1_B2   = 3'd3,
        CFG_MC_MD   = 3'd4,
        CFG_OSS     = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [15:0] raw_temperature;
        logic [18:0] raw_pressure;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] temperature;
        logic signed [31:0] pressure;
        logic               div_fault;
    } result_t;

    // Coefficients widened to 32-bit words, ready for the datapath
    typedef struct packed {
        logic [31:0] ac1;
        logic [31:0] ac2;
        logic [31:0] ac3;
        logic [31:0] ac4;
        logic [31:0] ac5;
        logic [31:0] ac6;
        logic [31:0] b1;
        logic [31:0] b2;
        logic [31:0] mc;
        logic [31:0] md;
        logic [1:0]  oss;
    } cal_t;

    function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] s);
        return 32'($signed(v) >>> s);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage

FILE: hdl/pressure_sensor_compensation_top.sv
// ----------------------------------------------------------------------------
// pressure_sensor_compensation_top
// Integer temperature and pressure compensation of raw barometric readings.
// ----------------------------------------------------------------------------
// Usage:
//   sample channel (sample_valid / sample_stall / sample) carries one item of
//   raw temperature and raw pressure. An item is taken at each edge with
//   sample_valid high and sample_stall low.
//   result channel (result_valid / result_stall / result) returns one item of
//   temperature (0.1 degC), pressure (Pa) and div_fault per sample.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes the five
//   packed calibration words and the oversampling setting; cfg_ready is
//   always high. Write only while the pipeline is empty.
// Timing:
//   74 register stages: the two 32-stage restoring dividers (temperature and
//   pressure) plus ten arithmetic stages.
//   Throughput is one item per cycle while result_stall does not hold the pipeline.
// Reset:
//   rst_n clears all valid bits and the calibration registers to zero.
// Stall:
//   While a result waits under result_stall the whole pipeline holds, and
//   sample_stall rises in the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module pressure_sensor_compensation_top
    import psc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    output logic        sample_stall,
    input  sample_t     sample,
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cal_t cal;
    logic en;

    assign cfg_ready = 1'b1;

    psc_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cal      (cal)
    );

    // Advance every stage unless the output item is held
    assign en           = !(result_valid && result_stall);
    assign sample_stall = !en;

    // ---- Stage 1: (UT - AC6) * AC5
    logic        v1_reg;
    logic [31:0] tprod1_reg;
    logic [18:0] up1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= sample_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tprod1_reg <= ({16'd0, sample.raw_temperature} - cal.ac6) * cal.ac5;
            up1_reg    <= sample.raw_pressure;
        end
    end

    // ---- Temperature division: (MC << 11) / (X1 + MD), sign-magnitude
    typedef struct packed {
        logic [31:0] x1;
        logic [18:0] up;
        logic        neg;
        logic        dz;
    } d1_side_t;

    logic [31:0] x1_s1, tnum, tden;
    d1_side_t    d1_in, d1_out;
    logic        d1_ov;
    logic [31:0] d1_q;

    always_comb
    begin
        x1_s1     = asr32(tprod1_reg, 5'd15);
        tnum      = cal.mc << 11;
        tden      = x1_s1 + cal.md;
        d1_in.x1  = x1_s1;
        d1_in.up  = up1_reg;
        d1_in.neg = tnum[31] ^ tden[31];
        d1_in.dz  = (tden == '0);
    end

    psc_div #(.SIDE_W($bits(d1_side_t))) u_div_t (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v1_reg),
        .num       (tnum[31] ? 32'(-tnum) : tnum),
        .den       (tden[31] ? 32'(-tden) : tden),
        .side_in   (d1_in),
        .out_valid (d1_ov),
        .quo       (d1_q),
        .side_out  (d1_out)
    );

    // ---- Stage 3: B5, temperature, B6
    logic        v3_reg, f3_reg;
    logic [31:0] b6_3_reg;
    logic [15:0] temp3_reg;
    logic [18:0] up3_reg;
    logic [31:0] x2_t, b5;

    always_comb
    begin
        if (d1_out.dz)
            x2_t = '0;
        else
            x2_t = d1_out.neg ? 32'(-d1_q) : d1_q;
        b5 = d1_out.x1 + x2_t;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= d1_ov;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b6_3_reg  <= b5 - B6_OFFSET;
            temp3_reg <= 16'(asr32(b5 + 32'd8, 5'd4));
            up3_reg   <= d1_out.up;
            f3_reg    <= d1_out.dz;
        end
    end

    // ---- Stage 4: B6*B6, AC2*B6, AC3*B6
    logic        v4_reg, f4_reg;
    logic [31:0] bb4_reg, a2b6_4_reg, a3b6_4_reg;
    logic [15:0] temp4_reg;
    logic [18:0] up4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (en)
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bb4_reg    <= b6_3_reg * b6_3_reg;
            a2b6_4_reg <= cal.ac2 * b6_3_reg;
            a3b6_4_reg <= cal.ac3 * b6_3_reg;
            temp4_reg  <= temp3_reg;
            up4_reg    <= up3_reg;
            f4_reg     <= f3_reg;
        end
    end

    // ---- Stage 5: B2*SQ, B1*SQ
    logic        v5_reg, f5_reg;
    logic [31:0] b2sq5_reg, b1sq5_reg, a2b6_5_reg, a3b6_5_reg;
    logic [15:0] temp5_reg;
    logic [18:0] up5_reg;
    logic [31:0] sq;

    assign sq = asr32(bb4_reg, 5'd12);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (en)
            v5_reg <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b2sq5_reg  <= cal.b2 * sq;
            b1sq5_reg  <= cal.b1 * sq;
            a2b6_5_reg <= a2b6_4_reg;
            a3b6_5_reg <= a3b6_4_reg;
            temp5_reg  <= temp4_reg;
            up5_reg    <= up4_reg;
            f5_reg     <= f4_reg;
        end
    end

    // ---- Stage 6: B3 and X3 for B4
    logic        v6_reg, f6_reg;
    logic [31:0] b3_6_reg, x3b_6_reg;
    logic [15:0] temp6_reg;
    logic [18:0] up6_reg;
    logic [31:0] x3a, b3_pre, x3b_sum;

    always_comb
    begin
        x3a     = asr32(b2sq5_reg, 5'd11) + asr32(a2b6_5_reg, 5'd11);
        b3_pre  = ((cal.ac1 << 2) + x3a) << cal.oss;
        x3b_sum = asr32(a3b6_5_reg, 5'd13) + asr32(b1sq5_reg, 5'd16) + 32'd2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v6_reg <= 1'b0;
        else if (en)
            v6_reg <= v5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b3_6_reg  <= asr32(b3_pre + 32'd2, 5'd2);
            x3b_6_reg <= asr32(x3b_sum, 5'd2);
            temp6_reg <= temp5_reg;
            up6_reg   <= up5_reg;
            f6_reg    <= f5_reg;
        end
    end

    // ---- Stage 7: AC4 * (X3 + 32768), (UP - B3) * (50000 >> OSS)
    logic        v7_reg, f7_reg;
    logic [31:0] b4p7_reg, b7_7_reg;
    logic [15:0] temp7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v7_reg <= 1'b0;
        else if (en)
            v7_reg <= v6_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b4p7_reg  <= cal.ac4 * (x3b_6_reg + B4_BIAS);
            b7_7_reg  <= ({13'd0, up6_reg} - b3_6_reg) * (B7_SCALE >> cal.oss);
            temp7_reg <= temp6_reg;
            f7_reg    <= f6_reg;
        end
    end

    // ---- Pressure division: B7 * 2 / B4, or B7 / B4 then * 2 when B7 is large
    typedef struct packed {
        logic        big;
        logic        b4z;
        logic        fault;
        logic [15:0] temp;
    } d2_side_t;

    logic [31:0] b4;
    d2_side_t    d2_in, d2_out;
    logic        d2_ov;
    logic [31:0] d2_q;

    always_comb
    begin
        b4          = b4p7_reg >> 15;
        d2_in.big   = b7_7_reg[31];
        d2_in.b4z   = (b4 == '0);
        d2_in.fault = f7_reg;
        d2_in.temp  = temp7_reg;
    end

    psc_div #(.SIDE_W($bits(d2_side_t))) u_div_p (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v7_reg),
        .num       (b7_7_reg[31] ? b7_7_reg : (b7_7_reg << 1)),
        .den       (b4),
        .side_in   (d2_in),
        .out_valid (d2_ov),
        .quo       (d2_q),
        .side_out  (d2_out)
    );

    // ---- Stage 9: p
    logic        v9_reg, f9_reg;
    logic [31:0] p9_reg;
    logic [15:0] temp9_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v9_reg <= 1'b0;
        else if (en)
            v9_reg <= d2_ov;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (d2_out.b4z)
                p9_reg <= '0;
            else
                p9_reg <= d2_out.big ? (d2_q << 1) : d2_q;
            f9_reg    <= d2_out.fault | d2_out.b4z;
            temp9_reg <= d2_out.temp;
        end
    end

    // ---- Stage 10: (p >> 8)^2 and -7357 * p
    logic        v10_reg, f10_reg;
    logic [31:0] p10_reg, xx10_reg, lin10_reg;
    logic [15:0] temp10_reg;
    logic [31:0] p_hi;

    assign p_hi = asr32(p9_reg, 5'd8);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v10_reg <= 1'b0;
        else if (en)
            v10_reg <= v9_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xx10_reg   <= p_hi * p_hi;
            lin10_reg  <= P_LIN_COEF * p9_reg;
            p10_reg    <= p9_reg;
            f10_reg    <= f9_reg;
            temp10_reg <= temp9_reg;
        end
    end

    // ---- Stage 11: square term * 3038
    logic        v11_reg, f11_reg;
    logic [31:0] p11_reg, sqt11_reg, lin11_reg;
    logic [15:0] temp11_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v11_reg <= 1'b0;
        else if (en)
            v11_reg <= v10_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqt11_reg  <= xx10_reg * P_SQ_COEF;
            lin11_reg  <= lin10_reg;
            p11_reg    <= p10_reg;
            f11_reg    <= f10_reg;
            temp11_reg <= temp10_reg;
        end
    end

    // ---- Output register: final pressure correction
    logic        out_v_reg;
    result_t     out_reg;
    logic [31:0] corr;

    assign corr = asr32(sqt11_reg, 5'd16) + asr32(lin11_reg, 5'd16) + P_OFFSET;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en)
            out_v_reg <= v11_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg.temperature <= temp11_reg;
            out_reg.pressure    <= p11_reg + asr32(corr, 5'd4);
            out_reg.div_fault   <= f11_reg;
        end
    end

    assign result_valid = out_v_reg;
    assign result       = out_reg;

    // ---- Assertions
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && !sample_stall) |=> v1_reg)
        else $error("accepted item did not enter stage 1");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(v9_reg) && $stable(v3_reg)))
        else $error("pipeline moved while output held");

    a_b4_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (en && d2_ov && d2_out.b4z) |=> (v9_reg && f9_reg && p9_reg == '0))
        else $error("zero pressure divisor not flagged");

endmodule

FILE: hdl/psc_cfg.sv
// ----------------------------------------------------------------------------
// psc_cfg
// Calibration register file; unpacks the packed words into coefficients.
// ----------------------------------------------------------------------------
module psc_cfg
    import psc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [31:0] wr_data,
    output cal_t        cal
);

    logic [31:0] ac12_reg, ac34_reg, ac56_reg, b12_reg, mcmd_reg;
    logic [1:0]  oss_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ac12_reg <= '0;
            ac34_reg <= '0;
            ac56_reg <= '0;
            b12_reg  <= '0;
            mcmd_reg <= '0;
            oss_reg  <= '0;
        end
        else if (wr_en)
        begin
            unique case (cfg_idx_t'(wr_index))
                CFG_AC1_AC2: ac12_reg <= wr_data;
                CFG_AC3_AC4: ac34_reg <= wr_data;
                CFG_AC5_AC6: ac56_reg <= wr_data;
                CFG_B1_B2:   b12_reg  <= wr_data;
                CFG_MC_MD:   mcmd_reg <= wr_data;
                CFG_OSS:     oss_reg  <= wr_data[1:0];
                default:     ;  // drop writes beyond the list
            endcase
        end
    end

    always_comb
    begin
        cal.ac1 = sx16(ac12_reg[31:16]);
        cal.ac2 = sx16(ac12_reg[15:0]);
        cal.ac3 = sx16(ac34_reg[31:16]);
        cal.ac4 = {16'd0, ac34_reg[15:0]};
        cal.ac5 = {16'd0, ac56_reg[31:16]};
        cal.ac6 = {16'd0, ac56_reg[15:0]};
        cal.b1  = sx16(b12_reg[31:16]);
        cal.b2  = sx16(b12_reg[15:0]);
        cal.mc  = sx16(mcmd_reg[31:16]);
        cal.md  = sx16(mcmd_reg[15:0]);
        cal.oss = oss_reg;
    end

endmodule

FILE: hdl/psc_div.sv
// ----------------------------------------------------------------------------
// psc_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module psc_div
    import psc_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [31:0]       num,
    input  logic [31:0]       den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [31:0]       quo,
    output logic [SIDE_W-1:0] side_out
);

    logic              v_reg    [DIV_BITS+1];
    logic [31:0]       rem_reg  [DIV_BITS+1];
    logic [31:0]       q_reg    [DIV_BITS+1];
    logic [31:0]       d_reg    [DIV_BITS+1];
    logic [SIDE_W-1:0] side_reg [DIV_BITS+1];

    assign v_reg[0]    = in_valid;
    assign rem_reg[0]  = '0;
    assign q_reg[0]    = num;
    assign d_reg[0]    = den;
    assign side_reg[0] = side_in;

    for (genvar k = 0; k < DIV_BITS; k++)
    begin : g_stage
        logic [32:0] trial;
        logic [32:0] diff;

        assign trial = {rem_reg[k], q_reg[k][31]};
        assign diff  = trial - {1'b0, d_reg[k]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k+1] <= 1'b0;
            else if (en)
                v_reg[k+1] <= v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                // keep the difference when the divisor fits
                rem_reg[k+1]  <= diff[32] ? trial[31:0] : diff[31:0];
                q_reg[k+1]    <= {q_reg[k][30:0], ~diff[32]};
                d_reg[k+1]    <= d_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = v_reg[DIV_BITS];
    assign quo       = q_reg[DIV_BITS];
    assign side_out  = side_reg[DIV_BITS];

endmodule
